// ===== rtl/mfr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_pkg
// Types and codes shared by the command front end and the drawing engine.
// ---------------------------------------------------------------------------
package mfr_pkg;

	localparam logic [2:0] ACT_CLEAR   = 3'd0;
	localparam logic [2:0] ACT_LINE    = 3'd1;
	localparam logic [2:0] ACT_OUTLINE = 3'd2;
	localparam logic [2:0] ACT_FILL    = 3'd3;
	localparam logic [2:0] ACT_GLYPH   = 3'd4;
	localparam logic [2:0] ACT_READ    = 3'd5;

	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic [7:0] BIT_LEFT   = 8'h80;

	// Internal coordinate: wide enough for origin plus size without wrapping.
	typedef logic signed [13:0] crd_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_CLEAR,
		K_LINE,
		K_OUTLINE,
		K_FILL,
		K_GLYPH,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [11:0] ax;
		logic signed [11:0] ay;
		logic signed [11:0] bx;
		logic signed [11:0] by;
		logic [12:0]        dx;
		logic signed [13:0] ndy;
		logic               stx_neg;
		logic               sty_neg;
		logic [34:0]        bits;
		logic [7:0]         scale;
		logic [13:0]        addr;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/monochrome_frame_rasterizer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// monochrome_frame_rasterizer
// 1-bit-per-pixel frame store with clear, line, rectangle, glyph and read requests.
// ---------------------------------------------------------------------------
// After reset the block sweeps the frame store to white, one byte per cycle
// over all ROW_BYTES * FRAME_HEIGHT bytes (15000 at the default size), with
// full held high. A drawing request then visits its pixels: a line visits
// max(|dx|,|dy|)+1 pixels, an outline 2*(w+h), a filled rectangle its clipped
// area, and a glyph the clipped areas of its set dots. A clear request writes
// every store byte white in the same sweep order. Pixels pass from the pixel
// walker through the single read-modify-write port of the frame store; a
// two-entry queue accepts new requests while one is being drawn, and each
// request returns one result.
module monochrome_frame_rasterizer #(
	parameter int FRAME_WIDTH  = 400,
	parameter int FRAME_HEIGHT = 300
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [2:0]         action,
	input  wire  signed [11:0] first_x,
	input  wire  signed [11:0] first_y,
	input  wire  signed [11:0] second_x,
	input  wire  signed [11:0] second_y,
	input  wire  [34:0]        glyph_bits,
	input  wire  [7:0]         glyph_scale,
	input  wire  [13:0]        read_address,
	output logic               empty,
	input  wire                pop,
	output logic [7:0]         read_data,
	output logic               read_valid
);
	import mfr_pkg::*;

	localparam int STORE_BYTES = ((FRAME_WIDTH + 7) / 8) * FRAME_HEIGHT;

	logic  q_valid, q_take, init_busy;
	cmd_t  q_cmd;

	mfr_front #(.STORE_BYTES(STORE_BYTES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.glyph_bits   (glyph_bits),
		.glyph_scale  (glyph_scale),
		.read_address (read_address),
		.init_busy    (init_busy),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_take       (q_take)
	);

	mfr_engine #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_take     (q_take),
		.init_busy  (init_busy),
		.empty      (empty),
		.pop        (pop),
		.read_data  (read_data),
		.read_valid (read_valid)
	);
endmodule
`default_nettype wire

// ===== rtl/mfr_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                    clk,
	input  wire                                    we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                       wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/mfr_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_front
// Accepts drawing requests, classifies them and holds them in a two-entry
// queue until the engine takes them.
// ---------------------------------------------------------------------------
module mfr_front #(
	parameter int STORE_BYTES = 15000
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  wire  [2:0]          action,
	input  wire  signed [11:0]  first_x,
	input  wire  signed [11:0]  first_y,
	input  wire  signed [11:0]  second_x,
	input  wire  signed [11:0]  second_y,
	input  wire  [34:0]         glyph_bits,
	input  wire  [7:0]          glyph_scale,
	input  wire  [13:0]         read_address,
	input  wire                 init_busy,
	output logic                q_valid,
	output mfr_pkg::cmd_t       q_cmd,
	input  wire                 q_take
);
	import mfr_pkg::*;

	cmd_t              ent_q [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        cnt_q;
	cmd_t              cls;
	logic signed [12:0] dxs, dys;
	logic              acc;

	always_comb begin
		dxs = 13'(second_x) - 13'(first_x);
		dys = 13'(second_y) - 13'(first_y);
		cls.ax      = first_x;
		cls.ay      = first_y;
		cls.bx      = second_x;
		cls.by      = second_y;
		cls.dx      = (dxs < 0) ? 13'(-dxs) : 13'(dxs);
		cls.ndy     = (dys < 0) ? 14'(dys) : -14'(dys);
		cls.stx_neg = !(first_x < second_x);
		cls.sty_neg = !(first_y < second_y);
		cls.bits    = glyph_bits;
		cls.scale   = glyph_scale;
		cls.addr    = read_address;
		case (action)
			ACT_CLEAR:   cls.kind = K_CLEAR;
			ACT_LINE:    cls.kind = K_LINE;
			ACT_OUTLINE: cls.kind = (second_x > 0 && second_y > 0) ? K_OUTLINE : K_NOP;
			ACT_FILL:    cls.kind = (second_x > 0 && second_y > 0) ? K_FILL : K_NOP;
			ACT_GLYPH:   cls.kind = (glyph_scale != 8'd0) ? K_GLYPH : K_NOP;
			ACT_READ:    cls.kind = (32'(read_address) < STORE_BYTES) ? K_READ : K_NOP;
			default:     cls.kind = K_NOP;
		endcase
	end

	assign full    = (cnt_q == 2'd2) || init_busy;
	assign acc     = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc) begin
				wptr_q <= !wptr_q;
			end
			if (q_take) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(q_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_take |-> cnt_q != 2'd0)
		else $error("engine took a request from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("request queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !q_take) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not follow an accepted request");
endmodule
`default_nettype wire

// ===== rtl/mfr_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_engine
// Walks the pixels of one request at a time, clips them and clears their bits
// in the frame store through a read-modify-write pipeline, or clears or reads it.
// ---------------------------------------------------------------------------
module mfr_engine #(
	parameter int FRAME_WIDTH  = 400,
	parameter int FRAME_HEIGHT = 300
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_valid,
	input  wire mfr_pkg::cmd_t q_cmd,
	output logic           q_take,
	output logic           init_busy,
	output logic           empty,
	input  wire            pop,
	output logic [7:0]     read_data,
	output logic           read_valid
);
	import mfr_pkg::*;

	localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
	localparam int ADDR_W      = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;
	localparam crd_t W_C = 14'(FRAME_WIDTH);
	localparam crd_t H_C = 14'(FRAME_HEIGHT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CLEAR = 11'b000_0000_0010,
		S_LINE  = 11'b000_0000_0100,
		S_OUTH  = 11'b000_0000_1000,
		S_OUTV  = 11'b000_0001_0000,
		S_FSET  = 11'b000_0010_0000,
		S_FILL  = 11'b000_0100_0000,
		S_GLYPH = 11'b000_1000_0000,
		S_READ  = 11'b001_0000_0000,
		S_RCAP  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	// Drain is the idle pipeline wait before a result; folded into S_DONE entry.
	state_t state_q;
	logic   init_q, drain_q;

	crd_t  cx_q, cy_q, ex_q, ey_q, bx_q, by_q, rx_q, ry_q;
	crd_t  fx_q, fy_q, fxe_q, fye_q, ox_q, oy_q, gx_q;
	logic signed [14:0] err_q;
	logic [12:0] dx_q;
	crd_t  ndy_q;
	logic  stx_neg_q, sty_neg_q, phase_q, from_glyph_q;
	logic [34:0] bits_q;
	logic [7:0]  scale_q;
	logic [2:0]  gr_q, gc_q;
	logic [13:0] rd_addr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [7:0]  pend_data_q;
	logic        pend_rv_q;
	logic        res_valid_q;
	logic [7:0]  res_data_q;
	logic        res_rv_q;

	// pixel pipeline
	logic              v_s1, v_s2;
	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic [7:0]        mask_s1, mask_s2;
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [7:0]        lw_data_q;

	logic              pix_v, pix_ok;
	crd_t              pix_x, pix_y;
	logic [21:0]       lin;
	logic signed [15:0] e2;
	logic              step_x, step_y;
	crd_t              lo_x, lo_y, hi_x, hi_y, scl;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata, base;
	logic              pop_ok;

	always_comb begin
		pix_v = 1'b0;
		pix_x = cx_q;
		pix_y = cy_q;
		case (state_q)
			S_LINE: pix_v = 1'b1;
			S_OUTH: begin
				pix_v = 1'b1;
				pix_y = phase_q ? ry_q : by_q;
			end
			S_OUTV: begin
				pix_v = 1'b1;
				pix_x = phase_q ? rx_q : bx_q;
			end
			S_FILL: pix_v = 1'b1;
			default: pix_v = 1'b0;
		endcase
	end

	assign pix_ok = pix_x >= 0 && pix_y >= 0 && pix_x < W_C && pix_y < H_C;
	assign lin    = 22'(pix_y[10:0]) * 22'(ROW_BYTES) + 22'(pix_x[10:3]);

	assign e2     = 16'(err_q) <<< 1;
	assign step_x = e2 >= 16'(ndy_q);
	assign step_y = e2 <= signed'({3'b000, dx_q});

	assign lo_x = (fx_q < 0) ? '0 : fx_q;
	assign lo_y = (fy_q < 0) ? '0 : fy_q;
	assign hi_x = (fxe_q > W_C) ? W_C : fxe_q;
	assign hi_y = (fye_q > H_C) ? H_C : fye_q;
	assign scl  = signed'({6'd0, scale_q});

	assign q_take    = (state_q == S_IDLE) && q_valid;
	assign init_busy = init_q;
	assign pop_ok    = pop && res_valid_q;

	// A pixel reads before its predecessor's write lands, so forward that write.
	assign base  = (lw_valid_q && lw_addr_q == addr_s2) ? lw_data_q : rdata;
	assign we    = (state_q == S_CLEAR) || v_s2;
	assign waddr = (state_q == S_CLEAR) ? clr_addr_q : addr_s2;
	assign wdata = (state_q == S_CLEAR) ? BYTE_WHITE : (base & ~mask_s2);
	assign raddr = (state_q == S_READ) ? ADDR_W'(rd_addr_q) : addr_s1;

	mfr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		addr_s1 <= lin[ADDR_W-1:0];
		mask_s1 <= BIT_LEFT >> pix_x[2:0];
		addr_s2 <= addr_s1;
		mask_s2 <= mask_s1;
		if (v_s2) begin
			lw_addr_q <= addr_s2;
			lw_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			lw_valid_q <= 1'b0;
		end else begin
			v_s1 <= pix_v && pix_ok;
			v_s2 <= v_s1;
			if (state_q == S_CLEAR) begin
				lw_valid_q <= 1'b0;
			end else if (v_s2) begin
				lw_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			init_q       <= 1'b1;
			drain_q      <= 1'b0;
			clr_addr_q   <= '0;
			cx_q <= '0; cy_q <= '0; ex_q <= '0; ey_q <= '0;
			bx_q <= '0; by_q <= '0; rx_q <= '0; ry_q <= '0;
			fx_q <= '0; fy_q <= '0; fxe_q <= '0; fye_q <= '0;
			ox_q <= '0; oy_q <= '0; gx_q <= '0;
			err_q        <= '0;
			dx_q         <= '0;
			ndy_q        <= '0;
			stx_neg_q    <= 1'b0;
			sty_neg_q    <= 1'b0;
			phase_q      <= 1'b0;
			from_glyph_q <= 1'b0;
			bits_q       <= '0;
			scale_q      <= '0;
			gr_q         <= '0;
			gc_q         <= '0;
			rd_addr_q    <= '0;
			pend_data_q  <= '0;
			pend_rv_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						pend_data_q <= '0;
						pend_rv_q   <= 1'b0;
						drain_q     <= 1'b0;
						case (q_cmd.kind)
							K_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= S_CLEAR;
							end
							K_LINE: begin
								cx_q      <= 14'(q_cmd.ax);
								cy_q      <= 14'(q_cmd.ay);
								ex_q      <= 14'(q_cmd.bx);
								ey_q      <= 14'(q_cmd.by);
								dx_q      <= q_cmd.dx;
								ndy_q     <= q_cmd.ndy;
								err_q     <= signed'({2'b00, q_cmd.dx}) + 15'(q_cmd.ndy);
								stx_neg_q <= q_cmd.stx_neg;
								sty_neg_q <= q_cmd.sty_neg;
								state_q   <= S_LINE;
							end
							K_OUTLINE: begin
								bx_q    <= 14'(q_cmd.ax);
								by_q    <= 14'(q_cmd.ay);
								rx_q    <= 14'(q_cmd.ax) + 14'(q_cmd.bx) - 14'sd1;
								ry_q    <= 14'(q_cmd.ay) + 14'(q_cmd.by) - 14'sd1;
								cx_q    <= 14'(q_cmd.ax);
								phase_q <= 1'b0;
								state_q <= S_OUTH;
							end
							K_FILL: begin
								fx_q         <= 14'(q_cmd.ax);
								fy_q         <= 14'(q_cmd.ay);
								fxe_q        <= 14'(q_cmd.ax) + 14'(q_cmd.bx);
								fye_q        <= 14'(q_cmd.ay) + 14'(q_cmd.by);
								from_glyph_q <= 1'b0;
								state_q      <= S_FSET;
							end
							K_GLYPH: begin
								gx_q    <= 14'(q_cmd.ax);
								ox_q    <= 14'(q_cmd.ax);
								oy_q    <= 14'(q_cmd.ay);
								bits_q  <= q_cmd.bits;
								scale_q <= q_cmd.scale;
								gr_q    <= '0;
								gc_q    <= '0;
								state_q <= S_GLYPH;
							end
							K_READ: begin
								rd_addr_q <= q_cmd.addr;
								state_q   <= S_READ;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_LINE: begin
					if (cx_q == ex_q && cy_q == ey_q) begin
						drain_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						err_q <= err_q + (step_x ? 15'(ndy_q) : 15'sd0)
							+ (step_y ? signed'({2'b00, dx_q}) : 15'sd0);
						if (step_x) begin
							cx_q <= stx_neg_q ? cx_q - 14'sd1 : cx_q + 14'sd1;
						end
						if (step_y) begin
							cy_q <= sty_neg_q ? cy_q - 14'sd1 : cy_q + 14'sd1;
						end
					end
				end
				S_OUTH: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (cx_q == rx_q) begin
							cy_q    <= by_q;
							state_q <= S_OUTV;
						end else begin
							cx_q <= cx_q + 14'sd1;
						end
					end
				end
				S_OUTV: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (cy_q == ry_q) begin
							drain_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							cy_q <= cy_q + 14'sd1;
						end
					end
				end
				S_FSET: begin
					if (lo_x >= hi_x || lo_y >= hi_y) begin
						drain_q <= !from_glyph_q;
						state_q <= from_glyph_q ? S_GLYPH : S_DONE;
					end else begin
						cx_q    <= lo_x;
						cy_q    <= lo_y;
						bx_q    <= lo_x;
						ex_q    <= hi_x;
						ey_q    <= hi_y;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (cx_q + 14'sd1 == ex_q) begin
						cx_q <= bx_q;
						if (cy_q + 14'sd1 == ey_q) begin
							drain_q <= !from_glyph_q;
							state_q <= from_glyph_q ? S_GLYPH : S_DONE;
						end else begin
							cy_q <= cy_q + 14'sd1;
						end
					end else begin
						cx_q <= cx_q + 14'sd1;
					end
				end
				S_GLYPH: begin
					if (gr_q == 3'd7) begin
						drain_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (bits_q[3'd4 - gc_q]) begin
							fx_q         <= ox_q;
							fy_q         <= oy_q;
							fxe_q        <= ox_q + scl;
							fye_q        <= oy_q + scl;
							from_glyph_q <= 1'b1;
							state_q      <= S_FSET;
						end
						if (gc_q == 3'd4) begin
							gc_q   <= '0;
							gr_q   <= gr_q + 3'd1;
							ox_q   <= gx_q;
							oy_q   <= oy_q + scl;
							bits_q <= bits_q >> 5;
						end else begin
							gc_q <= gc_q + 3'd1;
							ox_q <= ox_q + scl;
						end
					end
				end
				S_READ: state_q <= S_RCAP;
				S_RCAP: begin
					pend_data_q <= rdata;
					pend_rv_q   <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					// Pixels still in flight must land before the result shows.
					if (drain_q) begin
						if (!v_s1 && !v_s2) begin
							drain_q <= 1'b0;
						end
					end else if (!res_valid_q || pop) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
			res_rv_q    <= 1'b0;
		end else if (state_q == S_DONE && !drain_q && (!res_valid_q || pop)) begin
			res_valid_q <= 1'b1;
			res_data_q  <= pend_data_q;
			res_rv_q    <= pend_rv_q;
		end else if (pop_ok) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty      = !res_valid_q;
	assign read_data  = res_data_q;
	assign read_valid = res_rv_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the completion state");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !v_s1 && !v_s2)
		else $error("pixels still in flight while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> 32'(addr_s2) < STORE_BYTES)
		else $error("pixel write beyond the frame store");
	assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_take)
		else $error("request taken during the power-on clear");
endmodule
`default_nettype wire

// ===== tb/monochrome_frame_rasterizer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// monochrome_frame_rasterizer_tb
// Drives clear, line, rectangle, glyph, byte-read and unused-code requests
// into the rasterizer. A local copy of the frame store predicts every reply,
// and the replies are checked in order against it. The sender and the
// receiver idle at random, and the run also includes a long receiver stall.
// ---------------------------------------------------------------------------
module monochrome_frame_rasterizer_tb;
	import mfr_pkg::*;

	localparam int FW         = 400;
	localparam int FH         = 300;
	localparam int ROWB       = (FW + 7) / 8;
	localparam int NBYTES     = ROWB * FH;
	localparam int IDLE_LIMIT = 600000;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]         act;
		logic signed [11:0] ax;
		logic signed [11:0] ay;
		logic signed [11:0] bx;
		logic signed [11:0] by;
		logic [34:0]        bits;
		logic [7:0]         scale;
		logic [13:0]        addr;
	} draw_req_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
	} read_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               pop = 1'b0;
	logic [2:0]         action = '0;
	logic signed [11:0] first_x = '0;
	logic signed [11:0] first_y = '0;
	logic signed [11:0] second_x = '0;
	logic signed [11:0] second_y = '0;
	logic [34:0]        glyph_bits = '0;
	logic [7:0]         glyph_scale = '0;
	logic [13:0]        read_address = '0;
	wire                full;
	wire                empty;
	wire  [7:0]         read_data;
	wire                read_valid;

	draw_req_t   pending_reqs[$];
	read_reply_t expected_replies[$];
	logic [7:0]  frame_copy[NBYTES];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	logic stall_req = 1'b0;
	int  stall_left = 0;
	logic req_taken = 1'b0;
	int  idle_cycles = 0;
	int  errors = 0;
	int  n_requests = 0;
	int  n_replies = 0;
	int  n_byte_hits = 0;

	monochrome_frame_rasterizer #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(action), .first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y), .glyph_bits(glyph_bits),
		.glyph_scale(glyph_scale), .read_address(read_address),
		.empty(empty), .pop(pop), .read_data(read_data), .read_valid(read_valid)
	);

	always #1 clk = ~clk;

	// ---- frame store prediction ----
	function automatic void plot_black(int x, int y);
		if (x < 0 || y < 0 || x >= FW || y >= FH) return;
		frame_copy[y * ROWB + x / 8] &= ~(BIT_LEFT >> (x % 8));
	endfunction

	function automatic void fill_box(int x, int y, int w, int h);
		int xa, xb, ya, yb;
		if (w <= 0 || h <= 0) return;
		xa = x < 0 ? 0 : x;
		ya = y < 0 ? 0 : y;
		xb = x + w > FW ? FW : x + w;
		yb = y + h > FH ? FH : y + h;
		for (int yy = ya; yy < yb; yy++)
			for (int xx = xa; xx < xb; xx++)
				plot_black(xx, yy);
	endfunction

	function automatic void outline_box(int x, int y, int w, int h);
		if (w <= 0 || h <= 0) return;
		for (int i = x; i < x + w; i++) begin
			plot_black(i, y);
			plot_black(i, y + h - 1);
		end
		for (int i = y; i < y + h; i++) begin
			plot_black(x, i);
			plot_black(x + w - 1, i);
		end
	endfunction

	function automatic void walk_line(int xa, int ya, int xb, int yb);
		int dx, dy, stx, sty, err, e2;
		dx = xb > xa ? xb - xa : xa - xb;
		dy = -(yb > ya ? yb - ya : ya - yb);
		stx = xa < xb ? 1 : -1;
		sty = ya < yb ? 1 : -1;
		err = dx + dy;
		forever begin
			plot_black(xa, ya);
			if (xa == xb && ya == yb) break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				xa += stx;
			end
			if (e2 <= dx) begin
				err += dx;
				ya += sty;
			end
		end
	endfunction

	function automatic void stamp_glyph(int x, int y, logic [34:0] bits, int s);
		if (s == 0) return;
		for (int r = 0; r < 7; r++)
			for (int c = 0; c < 5; c++)
				if (bits[5 * r + 4 - c])
					fill_box(x + c * s, y + r * s, s, s);
	endfunction

	function automatic read_reply_t apply_request(draw_req_t q);
		read_reply_t rep;
		rep.data = '0;
		rep.valid = 1'b0;
		case (q.act)
			ACT_CLEAR: begin
				foreach (frame_copy[i]) frame_copy[i] = BYTE_WHITE;
			end
			ACT_LINE:    walk_line(q.ax, q.ay, q.bx, q.by);
			ACT_OUTLINE: outline_box(q.ax, q.ay, q.bx, q.by);
			ACT_FILL:    fill_box(q.ax, q.ay, q.bx, q.by);
			ACT_GLYPH:   stamp_glyph(q.ax, q.ay, q.bits, int'(q.scale));
			ACT_READ: begin
				if (q.addr < NBYTES) begin
					rep.data = frame_copy[q.addr];
					rep.valid = 1'b1;
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	// ---- request builders ----
	function automatic draw_req_t mk(logic [2:0] act, int ax, int ay, int bx, int by,
			logic [34:0] bits = '0, int scale = 0, int addr = 0);
		draw_req_t q;
		q.act = act;
		q.ax = ax[11:0];
		q.ay = ay[11:0];
		q.bx = bx[11:0];
		q.by = by[11:0];
		q.bits = bits;
		q.scale = scale[7:0];
		q.addr = addr[13:0];
		return q;
	endfunction

	function automatic logic [34:0] rand_bits();
		return 35'({$urandom, $urandom});
	endfunction

	// Most drawing lands in the top-left corner so that reads of that corner
	// see real pixel data rather than white bytes.
	function automatic draw_req_t random_request();
		int pick, ra;
		pick = $urandom_range(999);
		ra = $urandom_range(45) * ROWB + $urandom_range(14);
		if (pick < 400)
			return mk(ACT_READ, 0, 0, 0, 0, '0, 0, ra);
		if (pick < 560)
			return mk(ACT_LINE, $urandom_range(240) - 20, $urandom_range(70) - 10,
				$urandom_range(240) - 20, $urandom_range(70) - 10);
		if (pick < 660)
			return mk(ACT_OUTLINE, $urandom_range(130) - 10, $urandom_range(55) - 8,
				$urandom_range(50) - 4, $urandom_range(30) - 4);
		if (pick < 760)
			return mk(ACT_FILL, $urandom_range(130) - 10, $urandom_range(55) - 8,
				$urandom_range(40) - 4, $urandom_range(25) - 4);
		if (pick < 880)
			return mk(ACT_GLYPH, $urandom_range(120) - 10, $urandom_range(50) - 10,
				0, 0, rand_bits(), $urandom_range(5));
		if (pick < 920)
			return mk($urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7, $urandom, $urandom,
				$urandom, $urandom, rand_bits(), $urandom, $urandom);
		if (pick < 935)
			return mk(ACT_READ, 0, 0, 0, 0, '0, 0, $urandom_range(16383));
		if (pick < 990)
			return mk($urandom_range(1) ? ACT_LINE : ACT_OUTLINE, $urandom, $urandom,
				$urandom_range(1) ? $urandom : $urandom_range(300),
				$urandom_range(1) ? $urandom : $urandom_range(300),
				rand_bits(), $urandom, $urandom);
		if (pick < 995)
			return mk(ACT_GLYPH, $urandom, $urandom, $urandom, $urandom, rand_bits(),
				$urandom_range(255), $urandom);
		return mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, rand_bits(),
			$urandom, $urandom);
	endfunction

	// ---- driver ----
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !req_taken) begin
			// Request still waiting for the block; hold it.
		end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			action <= pending_reqs[0].act;
			first_x <= pending_reqs[0].ax;
			first_y <= pending_reqs[0].ay;
			second_x <= pending_reqs[0].bx;
			second_y <= pending_reqs[0].by;
			glyph_bits <= pending_reqs[0].bits;
			glyph_scale <= pending_reqs[0].scale;
			read_address <= pending_reqs[0].addr;
		end else begin
			push <= 1'b0;
		end
	end

	// ---- receiver ----
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_req) begin
			stall_left <= 2000;
			stall_req <= 1'b0;
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---- monitor, checker and watchdog ----
	always @(posedge clk) begin
		draw_req_t   q;
		read_reply_t want;
		if (arst_n) begin
			req_taken <= push && !full;
			if (push && !full) begin
				q = mk(action, first_x, first_y, second_x, second_y, glyph_bits,
					glyph_scale, read_address);
				expected_replies.push_back(apply_request(q));
				void'(pending_reqs.pop_front());
				n_requests++;
			end
			if (pop && !empty) begin
				n_replies++;
				if (read_valid) n_byte_hits++;
				if (expected_replies.size() == 0) begin
					errors++;
					$display("%0t: unexpected reply data=%h valid=%b", $time,
						read_data, read_valid);
				end else begin
					want = expected_replies.pop_front();
					if (read_data !== want.data) begin
						errors++;
						$display("%0t: read_data expected %h actual %h", $time,
							want.data, read_data);
					end
					if (read_valid !== want.valid) begin
						errors++;
						$display("%0t: read_valid expected %b actual %b", $time,
							want.valid, read_valid);
					end
				end
			end
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_replies.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_reqs.push_back(random_request());
	endtask

	initial begin
		foreach (frame_copy[i]) frame_copy[i] = BYTE_WHITE;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 28;
		recv_idle_pct = 61;
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, 0));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, NBYTES - 1));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, NBYTES));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, 16383));
		pending_reqs.push_back(mk(ACT_LINE, 5, 5, 5, 5));
		pending_reqs.push_back(mk(ACT_LINE, 10, 2, 30, 9));
		pending_reqs.push_back(mk(ACT_LINE, 30, 40, 12, 3));
		pending_reqs.push_back(mk(ACT_LINE, -2048, -2048, 2047, 2047));
		pending_reqs.push_back(mk(ACT_LINE, 2047, -2048, -2048, 2047));
		pending_reqs.push_back(mk(ACT_OUTLINE, 3, 20, 1, 9));
		pending_reqs.push_back(mk(ACT_OUTLINE, 3, 20, 0, 9));
		pending_reqs.push_back(mk(ACT_OUTLINE, -10, -10, 420, 320));
		pending_reqs.push_back(mk(ACT_FILL, 40, 10, 12, -1));
		pending_reqs.push_back(mk(ACT_FILL, 40, 10, 12, 5));
		pending_reqs.push_back(mk(ACT_GLYPH, 60, 10, 0, 0, '1, 0));
		pending_reqs.push_back(mk(ACT_GLYPH, -4, -4, 0, 0, '1, 3));
		pending_reqs.push_back(mk(ACT_GLYPH, 2047, 2047, 0, 0, '1, 255));
		pending_reqs.push_back(mk(ACT_SPARE6, -1, -1, -1, -1, '1, 255, 16383));
		pending_reqs.push_back(mk(ACT_SPARE7, 0, 0, 0, 0, '0, 0, 0));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, 0));
		pending_reqs.push_back(mk(ACT_FILL, -2048, -2048, 2047, 2047));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, 7000));
		pending_reqs.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
		pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0, 7000));
		queue_random(480);
		wait_drained();

		// Receiver stops for a long stretch while cheap reads keep arriving,
		// so the block fills up and has to hold off its input.
		@(posedge clk);
		stall_req = 1'b1;
		repeat (30) pending_reqs.push_back(mk(ACT_READ, 0, 0, 0, 0, '0, 0,
			$urandom_range(NBYTES - 1)));
		wait_drained();

		send_idle_pct = 61;
		recv_idle_pct = 28;
		queue_random(500);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(500);
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Covered %0d requests and %0d replies, %0d of them store bytes,",
			n_requests, n_replies, n_byte_hits);
		$display("across idle mixes, a long receiver stall and %0d mismatches.", errors);
		if (errors == 0 && expected_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
